@@ rtl/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  typedef enum logic [1:0] {
    CFG_UP_X = 2'd0,
    CFG_UP_Y = 2'd1,
    CFG_UP_Z = 2'd2
  } cfg_reg_e;

  // Matrix row index on the result channel
  typedef logic [1:0] row_idx_t;
  localparam row_idx_t ROW_FIRST = 2'd0;
  localparam row_idx_t ROW_LAST  = 2'd3;

  // Normaliser: magnitudes are scaled so the largest has its top bit here
  localparam int NORM_MSB  = 29;
  localparam int NORM_W    = NORM_MSB + 1;
  // Leading-one search chunk size
  localparam int CHUNK_W   = 8;
  // Square root steps, one result bit each
  localparam int ISQ_STEPS = NORM_W + 1;

  // Saturation limits, as magnitudes and as 32-bit results
  localparam logic [63:0] SAT_POS_MAG = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] SAT_NEG_MAG = 64'h0000_0000_8000_0000;
  localparam logic [31:0] ELEM_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] ELEM_MIN    = 32'h8000_0000;

endpackage

@@ rtl/look_at_view_matrix.sv @@
// Output: row 0 is shown once the request has passed through every stage; rows 1 to 3
//   follow in the next cycles when not stalled.
// Flow: the four-row output serialiser holds one matrix at a time; the pipeline takes
//   a request in any cycle unless stall_o is high while a finished matrix waits for it.
// Reset: all valid bits clear; up vector returns to (0, 1.0, 0).
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Left-handed look-at view matrix in signed fixed point: two pipelined
// normalisers, cross and dot products, and a four-row output serialiser.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  lav_pkg::cfg_idx_t   cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  // Request channel
  input  logic                valid_i,
  output logic                stall_o,
  input  logic signed [31:0]  eye_x_i,
  input  logic signed [31:0]  eye_y_i,
  input  logic signed [31:0]  eye_z_i,
  input  logic signed [31:0]  aim_x_i,
  input  logic signed [31:0]  aim_y_i,
  input  logic signed [31:0]  aim_z_i,
  // Result channel
  output logic                valid_o,
  input  logic                stall_i,
  output lav_pkg::row_idx_t   row_index_o,
  output logic signed [31:0]  elem_0_o,
  output logic signed [31:0]  elem_1_o,
  output logic signed [31:0]  elem_2_o,
  output logic                last_row_o
);
  import lav_pkg::*;

  localparam int UW   = FRAC_BITS + 2;   // unit vector component
  localparam int DW   = 33;              // aim minus eye
  localparam int PU   = 32 + UW;         // up times forward
  localparam int CW   = PU + 1;          // up cross forward
  localparam int CPW  = 2 * UW;          // forward times right
  localparam int CDW  = CPW + 1;
  localparam int CUW  = UW + 1;          // camera up component
  localparam int EPW  = UW + 32;         // axis times eye
  localparam int ESW  = EPW + 2;
  localparam int UPW  = CUW + 32;
  localparam int USW  = UPW + 2;
  localparam int TW1  = 96;
  localparam int TW2  = 96 + 3 * UW;

  logic en;

  // Configuration registers
  logic [2:0][31:0] up_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= '0;
      up_q[1] <= 32'(1) << FRAC_BITS;
      up_q[2] <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_UP_X) up_q[0] <= cfg_data_i;
      if (cfg_index_i == CFG_UP_Y) up_q[1] <= cfg_data_i;
      if (cfg_index_i == CFG_UP_Z) up_q[2] <= cfg_data_i;
    end
  end

  // Stage 0: register eye and direction
  logic                t0_v_q;
  logic [2:0][31:0]    t0_eye_q;
  logic [2:0][DW-1:0]  t0_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_eye_q <= {eye_z_i, eye_y_i, eye_x_i};
      t0_d_q[0] <= DW'(aim_x_i) - DW'(eye_x_i);
      t0_d_q[1] <= DW'(aim_y_i) - DW'(eye_y_i);
      t0_d_q[2] <= DW'(aim_z_i) - DW'(eye_z_i);
    end
  end

  // Forward axis
  logic                n1_v;
  logic [2:0][UW-1:0]  n1_u;
  logic [TW1-1:0]      n1_tag;

  lav_norm #(.WI(DW), .FB(FRAC_BITS), .TW(TW1)) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t0_v_q),
    .v_i     (t0_d_q),
    .tag_i   (t0_eye_q),
    .valid_o (n1_v),
    .u_o     (n1_u),
    .tag_o   (n1_tag)
  );

  // Stage 1: up times forward products
  logic                t1_v_q;
  logic signed [PU-1:0] t1_p_q [6];
  logic [2:0][UW-1:0]  t1_fwd_q;
  logic [TW1-1:0]      t1_eye_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_p_q[0] <= PU'($signed(up_q[1])) * PU'($signed(n1_u[2]));
      t1_p_q[1] <= PU'($signed(up_q[2])) * PU'($signed(n1_u[1]));
      t1_p_q[2] <= PU'($signed(up_q[2])) * PU'($signed(n1_u[0]));
      t1_p_q[3] <= PU'($signed(up_q[0])) * PU'($signed(n1_u[2]));
      t1_p_q[4] <= PU'($signed(up_q[0])) * PU'($signed(n1_u[1]));
      t1_p_q[5] <= PU'($signed(up_q[1])) * PU'($signed(n1_u[0]));
      t1_fwd_q  <= n1_u;
      t1_eye_q  <= n1_tag;
    end
  end

  // Stage 2: up cross forward
  logic                t2_v_q;
  logic [2:0][CW-1:0]  t2_c_q;
  logic [2:0][UW-1:0]  t2_fwd_q;
  logic [TW1-1:0]      t2_eye_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t2_c_q[i] <= CW'(t1_p_q[2*i]) - CW'(t1_p_q[2*i+1]);
      end
      t2_fwd_q <= t1_fwd_q;
      t2_eye_q <= t1_eye_q;
    end
  end

  // Right axis
  logic                n2_v;
  logic [2:0][UW-1:0]  n2_u;
  logic [TW2-1:0]      n2_tag;

  lav_norm #(.WI(CW), .FB(FRAC_BITS), .TW(TW2)) u_norm_rgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t2_v_q),
    .v_i     (t2_c_q),
    .tag_i   ({t2_eye_q, t2_fwd_q}),
    .valid_o (n2_v),
    .u_o     (n2_u),
    .tag_o   (n2_tag)
  );

  logic [2:0][UW-1:0] n2_fwd;
  logic [2:0][31:0]   n2_eye;
  assign n2_fwd = n2_tag[3*UW-1:0];
  assign n2_eye = n2_tag[TW2-1 -: TW1];

  // Stage 3: camera-up products and translation products
  logic                  t3_v_q;
  logic signed [CPW-1:0] t3_q_q  [6];
  logic signed [EPW-1:0] t3_er_q [3];
  logic signed [EPW-1:0] t3_ef_q [3];
  logic [2:0][UW-1:0]    t3_rgt_q, t3_fwd_q;
  logic [2:0][31:0]      t3_eye_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_q_q[0] <= CPW'($signed(n2_fwd[1])) * CPW'($signed(n2_u[2]));
      t3_q_q[1] <= CPW'($signed(n2_fwd[2])) * CPW'($signed(n2_u[1]));
      t3_q_q[2] <= CPW'($signed(n2_fwd[2])) * CPW'($signed(n2_u[0]));
      t3_q_q[3] <= CPW'($signed(n2_fwd[0])) * CPW'($signed(n2_u[2]));
      t3_q_q[4] <= CPW'($signed(n2_fwd[0])) * CPW'($signed(n2_u[1]));
      t3_q_q[5] <= CPW'($signed(n2_fwd[1])) * CPW'($signed(n2_u[0]));
      for (int i = 0; i < 3; i++) begin
        t3_er_q[i] <= EPW'($signed(n2_u[i])) * EPW'($signed(n2_eye[i]));
        t3_ef_q[i] <= EPW'($signed(n2_fwd[i])) * EPW'($signed(n2_eye[i]));
      end
      t3_rgt_q <= n2_u;
      t3_fwd_q <= n2_fwd;
      t3_eye_q <= n2_eye;
    end
  end

  // Stage 4: camera-up differences and dot sums
  logic                  t4_v_q;
  logic signed [CDW-1:0] t4_cd_q [3];
  logic signed [ESW-1:0] t4_sr_q, t4_sf_q;
  logic [2:0][UW-1:0]    t4_rgt_q, t4_fwd_q;
  logic [2:0][31:0]      t4_eye_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t4_cd_q[i] <= CDW'(t3_q_q[2*i]) - CDW'(t3_q_q[2*i+1]);
      end
      t4_sr_q  <= ESW'(t3_er_q[0]) + ESW'(t3_er_q[1]) + ESW'(t3_er_q[2]);
      t4_sf_q  <= ESW'(t3_ef_q[0]) + ESW'(t3_ef_q[1]) + ESW'(t3_ef_q[2]);
      t4_rgt_q <= t3_rgt_q;
      t4_fwd_q <= t3_fwd_q;
      t4_eye_q <= t3_eye_q;
    end
  end

  // Stage 5: round half away from zero
  logic                  t5_v_q;
  logic [CDW-1:0]        cmag [3];
  logic [CDW-1:0]        crnd [3];
  logic [2:0][CUW-1:0]   t5_cup_d, t5_cup_q;
  logic [ESW-1:0]        smag_r, smag_f;
  logic [ESW-1:0]        t5_rr_d, t5_rr_q, t5_rf_d, t5_rf_q;
  logic                  t5_rn_q, t5_fn_q;
  logic [2:0][UW-1:0]    t5_rgt_q, t5_fwd_q;
  logic [2:0][31:0]      t5_eye_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = t4_cd_q[i][CDW-1] ? CDW'(-t4_cd_q[i]) : CDW'(t4_cd_q[i]);
      crnd[i] = (cmag[i] + (CDW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      t5_cup_d[i] = t4_cd_q[i][CDW-1] ? -CUW'(crnd[i]) : CUW'(crnd[i]);
    end
    smag_r  = t4_sr_q[ESW-1] ? ESW'(-t4_sr_q) : ESW'(t4_sr_q);
    smag_f  = t4_sf_q[ESW-1] ? ESW'(-t4_sf_q) : ESW'(t4_sf_q);
    t5_rr_d = (smag_r + (ESW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    t5_rf_d = (smag_f + (ESW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_cup_q <= t5_cup_d;
      t5_rr_q  <= t5_rr_d;
      t5_rf_q  <= t5_rf_d;
      t5_rn_q  <= t4_sr_q[ESW-1];
      t5_fn_q  <= t4_sf_q[ESW-1];
      t5_rgt_q <= t4_rgt_q;
      t5_fwd_q <= t4_fwd_q;
      t5_eye_q <= t4_eye_q;
    end
  end

  // Stage 6: negate and saturate right/forward translation, camera-up products
  logic                  t6_v_q;
  logic [31:0]           t6_trr_d, t6_trr_q, t6_trf_d, t6_trf_q;
  logic signed [UPW-1:0] t6_eu_q [3];
  logic [2:0][UW-1:0]    t6_rgt_q, t6_fwd_q;
  logic [2:0][CUW-1:0]   t6_cup_q;

  always_comb begin
    if (t5_rn_q) begin
      t6_trr_d = (t5_rr_q > ESW'(SAT_POS_MAG)) ? ELEM_MAX : t5_rr_q[31:0];
    end else begin
      t6_trr_d = (t5_rr_q > ESW'(SAT_NEG_MAG)) ? ELEM_MIN : (~t5_rr_q[31:0] + 32'd1);
    end
    if (t5_fn_q) begin
      t6_trf_d = (t5_rf_q > ESW'(SAT_POS_MAG)) ? ELEM_MAX : t5_rf_q[31:0];
    end else begin
      t6_trf_d = (t5_rf_q > ESW'(SAT_NEG_MAG)) ? ELEM_MIN : (~t5_rf_q[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t6_trr_q <= t6_trr_d;
      t6_trf_q <= t6_trf_d;
      for (int i = 0; i < 3; i++) begin
        t6_eu_q[i] <= UPW'($signed(t5_cup_q[i])) * UPW'($signed(t5_eye_q[i]));
      end
      t6_rgt_q <= t5_rgt_q;
      t6_fwd_q <= t5_fwd_q;
      t6_cup_q <= t5_cup_q;
    end
  end

  // Stage 7: camera-up dot sum
  logic                  t7_v_q;
  logic signed [USW-1:0] t7_su_q;
  logic [31:0]           t7_trr_q, t7_trf_q;
  logic [2:0][UW-1:0]    t7_rgt_q, t7_fwd_q;
  logic [2:0][CUW-1:0]   t7_cup_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t7_su_q  <= USW'(t6_eu_q[0]) + USW'(t6_eu_q[1]) + USW'(t6_eu_q[2]);
      t7_trr_q <= t6_trr_q;
      t7_trf_q <= t6_trf_q;
      t7_rgt_q <= t6_rgt_q;
      t7_fwd_q <= t6_fwd_q;
      t7_cup_q <= t6_cup_q;
    end
  end

  // Stage 8: round camera-up dot sum
  logic                  t8_v_q;
  logic [USW-1:0]        umag;
  logic [USW-1:0]        t8_ru_d, t8_ru_q;
  logic                  t8_un_q;
  logic [31:0]           t8_trr_q, t8_trf_q;
  logic [2:0][UW-1:0]    t8_rgt_q, t8_fwd_q;
  logic [2:0][CUW-1:0]   t8_cup_q;

  always_comb begin
    umag    = t7_su_q[USW-1] ? USW'(-t7_su_q) : USW'(t7_su_q);
    t8_ru_d = (umag + (USW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t8_ru_q  <= t8_ru_d;
      t8_un_q  <= t7_su_q[USW-1];
      t8_trr_q <= t7_trr_q;
      t8_trf_q <= t7_trf_q;
      t8_rgt_q <= t7_rgt_q;
      t8_fwd_q <= t7_fwd_q;
      t8_cup_q <= t7_cup_q;
    end
  end

  // Stage 9: negate and saturate camera-up translation
  logic                  t9_v_q;
  logic [31:0]           t9_tru_d, t9_tru_q;
  logic [31:0]           t9_trr_q, t9_trf_q;
  logic [2:0][UW-1:0]    t9_rgt_q, t9_fwd_q;
  logic [2:0][CUW-1:0]   t9_cup_q;

  always_comb begin
    if (t8_un_q) begin
      t9_tru_d = (t8_ru_q > USW'(SAT_POS_MAG)) ? ELEM_MAX : t8_ru_q[31:0];
    end else begin
      t9_tru_d = (t8_ru_q > USW'(SAT_NEG_MAG)) ? ELEM_MIN : (~t8_ru_q[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t9_tru_q <= t9_tru_d;
      t9_trr_q <= t8_trr_q;
      t9_trf_q <= t8_trf_q;
      t9_rgt_q <= t8_rgt_q;
      t9_fwd_q <= t8_fwd_q;
      t9_cup_q <= t8_cup_q;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_v_q <= 1'b0;
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
      t5_v_q <= 1'b0;
      t6_v_q <= 1'b0;
      t7_v_q <= 1'b0;
      t8_v_q <= 1'b0;
      t9_v_q <= 1'b0;
    end else if (en) begin
      t0_v_q <= valid_i;
      t1_v_q <= n1_v;
      t2_v_q <= t1_v_q;
      t3_v_q <= n2_v;
      t4_v_q <= t3_v_q;
      t5_v_q <= t4_v_q;
      t6_v_q <= t5_v_q;
      t7_v_q <= t6_v_q;
      t8_v_q <= t7_v_q;
      t9_v_q <= t8_v_q;
    end
  end

  // Output serialiser: holds one matrix, sends four rows
  logic [2:0][31:0] mat_q [4];
  logic             full_q;
  row_idx_t         row_q;
  logic             take;
  logic             load;

  assign take    = !full_q || (row_q == ROW_LAST && !stall_i);
  assign en      = !t9_v_q || take;
  assign load    = en && t9_v_q;
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      row_q  <= ROW_FIRST;
    end else if (load) begin
      full_q <= 1'b1;
      row_q  <= ROW_FIRST;
    end else if (full_q && !stall_i) begin
      if (row_q == ROW_LAST) begin
        full_q <= 1'b0;
        row_q  <= ROW_FIRST;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int r = 0; r < 3; r++) begin
        mat_q[r][0] <= 32'($signed(t9_rgt_q[r]));
        mat_q[r][1] <= 32'($signed(t9_cup_q[r]));
        mat_q[r][2] <= 32'($signed(t9_fwd_q[r]));
      end
      mat_q[3][0] <= t9_trr_q;
      mat_q[3][1] <= t9_tru_q;
      mat_q[3][2] <= t9_trf_q;
    end
  end

  assign valid_o     = full_q;
  assign row_index_o = row_q;
  assign elem_0_o    = mat_q[row_q][0];
  assign elem_1_o    = mat_q[row_q][1];
  assign elem_2_o    = mat_q[row_q][2];
  assign last_row_o  = (row_q == ROW_LAST);

  // Rows step by one within a matrix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && row_index_o != ROW_LAST)
      |=> (valid_o && row_index_o == $past(row_index_o) + 2'd1))
    else $error("row sequence broken");

  // Requests are held back only while a matrix is being sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("stall without pending matrix");

  // An accepted request enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> t0_v_q)
    else $error("accepted request lost");

  // Last row taken with nothing behind it empties the serialiser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && row_index_o == ROW_LAST && !t9_v_q) |=> !valid_o)
    else $error("matrix repeated");

endmodule

@@ rtl/lav_norm.sv @@
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normaliser: scale to a fixed magnitude window, sum of
// squares, bit-serial square root and restoring division, one stage per step.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int WI = 33,
  parameter int FB = 16,
  parameter int TW = 96
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][WI-1:0]  v_i,
  input  logic [TW-1:0]       tag_i,
  output logic                valid_o,
  output logic [2:0][FB+1:0]  u_o,
  output logic [TW-1:0]       tag_o
);
  import lav_pkg::*;

  localparam int NCH  = (WI + CHUNK_W - 1) / CHUNK_W;
  localparam int PADW = NCH * CHUNK_W;
  localparam int PW   = $clog2(PADW);
  localparam int CPW  = $clog2(CHUNK_W);
  localparam int SQW  = 2 * NORM_W;
  localparam int SUMW = SQW + 2;
  localparam int IW   = SUMW + 2;
  localparam int LW   = NORM_W + 1;
  localparam int QW   = FB + 1;
  localparam int NW   = LW + FB + 1;
  localparam int UW   = FB + 2;

  // Stage 1: magnitudes, signs, OR of magnitudes
  logic                s1_v_q;
  logic [2:0][WI-1:0]  s1_m_d, s1_m_q;
  logic [2:0]          s1_neg_d, s1_neg_q;
  logic [WI-1:0]       s1_or_d, s1_or_q;
  logic [TW-1:0]       s1_tag_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_d[i] = v_i[i][WI-1];
      s1_m_d[i]   = v_i[i][WI-1] ? (~v_i[i] + WI'(1)) : v_i[i];
    end
    s1_or_d = s1_m_d[0] | s1_m_d[1] | s1_m_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_m_q   <= s1_m_d;
      s1_neg_q <= s1_neg_d;
      s1_or_q  <= s1_or_d;
      s1_tag_q <= tag_i;
    end
  end

  // Stage 2: per-chunk non-zero flags and local leading-one positions
  logic                     s2_v_q;
  logic [PADW-1:0]          or_pad;
  logic [NCH-1:0]           s2_nz_d, s2_nz_q;
  logic [NCH-1:0][CPW-1:0]  s2_lp_d, s2_lp_q;
  logic [2:0][WI-1:0]       s2_m_q;
  logic [2:0]               s2_neg_q;
  logic [TW-1:0]            s2_tag_q;

  always_comb begin
    or_pad = PADW'(s1_or_q);
    for (int k = 0; k < NCH; k++) begin
      s2_nz_d[k] = |or_pad[k*CHUNK_W +: CHUNK_W];
      s2_lp_d[k] = '0;
      for (int b = 0; b < CHUNK_W; b++) begin
        if (or_pad[k*CHUNK_W + b]) begin
          s2_lp_d[k] = CPW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_nz_q  <= s2_nz_d;
      s2_lp_q  <= s2_lp_d;
      s2_m_q   <= s1_m_q;
      s2_neg_q <= s1_neg_q;
      s2_tag_q <= s1_tag_q;
    end
  end

  // Stage 3: leading-one position of the largest magnitude
  logic                s3_v_q;
  logic [PW-1:0]       s3_p_d, s3_p_q;
  logic                s3_zero_d, s3_zero_q;
  logic [2:0][WI-1:0]  s3_m_q;
  logic [2:0]          s3_neg_q;
  logic [TW-1:0]       s3_tag_q;

  always_comb begin
    s3_p_d = '0;
    for (int k = 0; k < NCH; k++) begin
      if (s2_nz_q[k]) begin
        s3_p_d = PW'(k * CHUNK_W) + PW'(s2_lp_q[k]);
      end
    end
    s3_zero_d = ~|s2_nz_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_p_q    <= s3_p_d;
      s3_zero_q <= s3_zero_d;
      s3_m_q    <= s2_m_q;
      s3_neg_q  <= s2_neg_q;
      s3_tag_q  <= s2_tag_q;
    end
  end

  // Stage 4: shift every magnitude into the window; right shifts truncate
  logic                    s4_v_q;
  logic [2:0][WI-1:0]      s4_rs;
  logic [2:0][NORM_W-1:0]  s4_m_d, s4_m_q;
  logic [2:0]              s4_neg_q;
  logic                    s4_zero_q;
  logic [TW-1:0]           s4_tag_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_rs[i] = s3_m_q[i] >> (s3_p_q - PW'(NORM_MSB));
      if (s3_p_q >= PW'(NORM_MSB)) begin
        s4_m_d[i] = s4_rs[i][NORM_W-1:0];
      end else begin
        s4_m_d[i] = NORM_W'(s3_m_q[i]) << (PW'(NORM_MSB) - s3_p_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_m_q    <= s4_m_d;
      s4_neg_q  <= s3_neg_q;
      s4_zero_q <= s3_zero_q;
      s4_tag_q  <= s3_tag_q;
    end
  end

  // Stage 5: squares
  logic                    s5_v_q;
  logic [2:0][SQW-1:0]     s5_sq_q;
  logic [2:0][NORM_W-1:0]  s5_m_q;
  logic [2:0]              s5_neg_q;
  logic                    s5_zero_q;
  logic [TW-1:0]           s5_tag_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq_q[i] <= SQW'(s4_m_q[i]) * SQW'(s4_m_q[i]);
      end
      s5_m_q    <= s4_m_q;
      s5_neg_q  <= s4_neg_q;
      s5_zero_q <= s4_zero_q;
      s5_tag_q  <= s4_tag_q;
    end
  end

  // Square root pipeline; entry 0 holds the sum of squares
  logic                    ic_v_q    [ISQ_STEPS+1];
  logic [IW-1:0]           ic_n_q    [ISQ_STEPS+1];
  logic [IW-1:0]           ic_r_q    [ISQ_STEPS+1];
  logic [2:0][NORM_W-1:0]  ic_m_q    [ISQ_STEPS+1];
  logic [2:0]              ic_neg_q  [ISQ_STEPS+1];
  logic                    ic_zero_q [ISQ_STEPS+1];
  logic [TW-1:0]           ic_tag_q  [ISQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ic_n_q[0]    <= IW'(SUMW'(s5_sq_q[0]) + SUMW'(s5_sq_q[1]) + SUMW'(s5_sq_q[2]));
      ic_r_q[0]    <= '0;
      ic_m_q[0]    <= s5_m_q;
      ic_neg_q[0]  <= s5_neg_q;
      ic_zero_q[0] <= s5_zero_q;
      ic_tag_q[0]  <= s5_tag_q;
    end
  end

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
    localparam logic [IW-1:0] STEP_BIT = IW'(1) << (2 * (ISQ_STEPS - 1 - j));
    logic [IW-1:0] trial;
    assign trial = ic_r_q[j] + STEP_BIT;

    // One root bit per stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ic_n_q[j] >= trial) begin
          ic_n_q[j+1] <= ic_n_q[j] - trial;
          ic_r_q[j+1] <= (ic_r_q[j] >> 1) + STEP_BIT;
        end else begin
          ic_n_q[j+1] <= ic_n_q[j];
          ic_r_q[j+1] <= ic_r_q[j] >> 1;
        end
        ic_m_q[j+1]    <= ic_m_q[j];
        ic_neg_q[j+1]  <= ic_neg_q[j];
        ic_zero_q[j+1] <= ic_zero_q[j];
        ic_tag_q[j+1]  <= ic_tag_q[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ic_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        ic_v_q[j+1] <= ic_v_q[j];
      end
    end
  end

  // Division pipeline; entry 0 holds the rounded numerators
  logic                 dv_v_q    [QW+1];
  logic [2:0][NW-1:0]   dv_n_q    [QW+1];
  logic [2:0][QW-1:0]   dv_q_q    [QW+1];
  logic [LW-1:0]        dv_l_q    [QW+1];
  logic [2:0]           dv_neg_q  [QW+1];
  logic                 dv_zero_q [QW+1];
  logic [TW-1:0]        dv_tag_q  [QW+1];
  logic [LW-1:0]        root_len;

  assign root_len = ic_r_q[ISQ_STEPS][LW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_n_q[0][i] <= (NW'(ic_m_q[ISQ_STEPS][i]) << FB) + NW'(root_len >> 1);
      end
      dv_q_q[0]    <= '0;
      dv_l_q[0]    <= root_len;
      dv_neg_q[0]  <= ic_neg_q[ISQ_STEPS];
      dv_zero_q[0] <= ic_zero_q[ISQ_STEPS];
      dv_tag_q[0]  <= ic_tag_q[ISQ_STEPS];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = FB - k;
    logic [NW-1:0] dsor;
    assign dsor = NW'(dv_l_q[k]) << SH;

    // One quotient bit per stage, three lanes
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_n_q[k][i] >= dsor) begin
            dv_n_q[k+1][i] <= dv_n_q[k][i] - dsor;
            dv_q_q[k+1][i] <= dv_q_q[k][i] | (QW'(1) << SH);
          end else begin
            dv_n_q[k+1][i] <= dv_n_q[k][i];
            dv_q_q[k+1][i] <= dv_q_q[k][i];
          end
        end
        dv_l_q[k+1]    <= dv_l_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_zero_q[k+1] <= dv_zero_q[k];
        dv_tag_q[k+1]  <= dv_tag_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end
  end

  // Output stage: restore signs, zero vector gives zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_q[QW]) begin
          u_o[i] <= '0;
        end else if (dv_neg_q[QW][i]) begin
          u_o[i] <= -UW'(dv_q_q[QW][i]);
        end else begin
          u_o[i] <= UW'(dv_q_q[QW][i]);
        end
      end
      tag_o <= dv_tag_q[QW];
    end
  end

  // Valid bits of the named stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      s5_v_q    <= 1'b0;
      ic_v_q[0] <= 1'b0;
      dv_v_q[0] <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      s1_v_q    <= valid_i;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      s5_v_q    <= s4_v_q;
      ic_v_q[0] <= s5_v_q;
      dv_v_q[0] <= ic_v_q[ISQ_STEPS];
      valid_o   <= dv_v_q[QW];
    end
  end

endmodule
